// ===== rtl/qvr_pkg.sv =====
// Shared widths, codes and sideband types of the quaternion vector rotation core.
package qvr_pkg;

   localparam int DATA_W   = 32;               // Q16.16 ports
   localparam int QN_FRAC  = 30;               // unit quaternion is Q2.30
   localparam int MAG_W    = 31;               // block-scaled magnitude, <= 2^30
   localparam int SQ_W     = 2 * MAG_W;        // one square
   localparam int SUM_W    = SQ_W + 1;         // sum of four squares, <= 2^62
   localparam int ROOT_W   = 32;               // floor sqrt, <= 2^31
   localparam int SQX_W    = 2 * ROOT_W;       // radicand padded to whole digit pairs
   localparam int SQREM_W  = ROOT_W + 3;       // partial remainder of the root
   localparam int SQ_STAGES = ROOT_W;          // one root bit per stage
   localparam int NUM_W    = MAG_W + QN_FRAC;  // dividend mag*2^30 + m/2
   localparam int Q_W      = QN_FRAC + 1;      // quotient, <= 2^30
   localparam int DREM_W   = ROOT_W;           // partial remainder, < m
   localparam int T_W      = 35;               // first product components
   localparam int P1_W     = 2 * DATA_W;       // qn * v
   localparam int S1_W     = P1_W + 2;         // three-term sum
   localparam int P2_W     = T_W + DATA_W;     // t * qn
   localparam int S2_W     = P2_W + 2;         // four-term sum
   localparam int R_W      = 40;               // rotated component before clamp

   localparam logic CMD_INVERSE = 1'b1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef struct packed {
      logic                          valid;
      logic                          cmd;
      logic [3:0]                    neg;
      logic                          zero;
      logic [2:0][DATA_W-1:0]        vec;
   } dv_side_type;

   typedef struct packed {
      dv_side_type                   base;
      logic [3:0][MAG_W-1:0]         mag;
   } sq_side_type;

endpackage

// ===== rtl/qvr_sqrt.sv =====
// Pipelined restoring integer square root, one root bit per stage.
module qvr_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  qvr_pkg::sq_side_type               in_side,
   input  logic [qvr_pkg::SUM_W-1:0]          in_sum,
   output qvr_pkg::sq_side_type               out_side,
   output logic [qvr_pkg::ROOT_W-1:0]         out_root
);

   localparam int N   = qvr_pkg::SQ_STAGES;
   localparam int RW  = qvr_pkg::ROOT_W;
   localparam int XW  = qvr_pkg::SQX_W;
   localparam int REW = qvr_pkg::SQREM_W;

   logic [REW-1:0]       rem_ff  [N];
   logic [RW-1:0]        root_ff [N];
   logic [XW-1:0]        x_ff    [N];
   qvr_pkg::sq_side_type side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [REW-1:0]       rem_prev, rem_sh, trial, rem_in;
      logic [RW-1:0]        root_prev, root_in;
      logic [XW-1:0]        x_prev;
      qvr_pkg::sq_side_type side_prev;
      logic                 ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign x_prev    = XW'(in_sum);
         assign side_prev = in_side;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign x_prev    = x_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         rem_sh  = {rem_prev[REW-3:0], x_prev[XW-1-2*k -: 2]};
         trial   = REW'({root_prev, 2'b01});
         ge      = (rem_sh >= trial);
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {root_prev[RW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en && !reset) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            x_ff[k]    <= x_prev;
            side_ff[k] <= side_prev;
         end
         if (reset) begin
            side_ff[k].base.valid <= 1'b0;
         end
      end
   end

   assign out_side = side_ff[N-1];
   assign out_root = root_ff[N-1];

endmodule

// ===== rtl/qvr_div.sv =====
// Pipelined four-lane restoring divider: round(mag * 2^30 / m), one quotient bit per stage.
module qvr_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  qvr_pkg::dv_side_type                   in_side,
   input  logic [3:0][qvr_pkg::MAG_W-1:0]         in_mag,
   input  logic [qvr_pkg::ROOT_W-1:0]             in_m,
   output qvr_pkg::dv_side_type                   out_side,
   output logic [3:0][qvr_pkg::Q_W-1:0]           out_q
);

   localparam int N   = qvr_pkg::Q_W;
   localparam int NW  = qvr_pkg::NUM_W;
   localparam int DW  = qvr_pkg::DREM_W;
   localparam int RW  = qvr_pkg::ROOT_W;
   localparam int QF  = qvr_pkg::QN_FRAC;

   // prep stage: dividend with rounding half folded in
   logic [3:0][NW-1:0]   num_p_ff;
   logic [RW-1:0]        m_p_ff;
   qvr_pkg::dv_side_type side_p_ff;

   always_ff @(posedge clock) begin
      if (en && !reset) begin
         for (int i = 0; i < 4; i++) begin
            num_p_ff[i] <= NW'({in_mag[i], {QF{1'b0}}}) + NW'(in_m >> 1);
         end
         m_p_ff    <= in_m;
         side_p_ff <= in_side;
      end
      if (reset) begin
         side_p_ff.valid <= 1'b0;
      end
   end

   logic [3:0][DW-1:0]   rem_ff  [N];
   logic [3:0][N-1:0]    q_ff    [N];
   logic [3:0][NW-1:0]   num_ff  [N];
   logic [RW-1:0]        m_ff    [N];
   qvr_pkg::dv_side_type side_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic [3:0][DW-1:0]   rem_prev, rem_in;
      logic [3:0][N-1:0]    q_prev, q_in;
      logic [3:0][NW-1:0]   num_prev;
      logic [RW-1:0]        m_prev;
      qvr_pkg::dv_side_type side_prev;
      logic [DW:0]          rem_sh;
      logic                 ge;

      if (j == 0) begin : g_first
         for (genvar i = 0; i < 4; i++) begin : g_lane
            assign rem_prev[i] = DW'(num_p_ff[i][NW-1:N]);
         end
         assign q_prev    = '0;
         assign num_prev  = num_p_ff;
         assign m_prev    = m_p_ff;
         assign side_prev = side_p_ff;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign q_prev    = q_ff[j-1];
         assign num_prev  = num_ff[j-1];
         assign m_prev    = m_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      always_comb begin
         rem_in = '0;
         q_in   = '0;
         rem_sh = '0;
         ge     = 1'b0;
         for (int i = 0; i < 4; i++) begin
            rem_sh    = {rem_prev[i], num_prev[i][N-1-j]};
            ge        = (rem_sh >= {1'b0, m_prev});
            rem_in[i] = ge ? DW'(rem_sh - {1'b0, m_prev}) : DW'(rem_sh);
            q_in[i]   = {q_prev[i][N-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (en && !reset) begin
            rem_ff[j]  <= rem_in;
            q_ff[j]    <= q_in;
            num_ff[j]  <= num_prev;
            m_ff[j]    <= m_prev;
            side_ff[j] <= side_prev;
         end
         if (reset) begin
            side_ff[j].valid <= 1'b0;
         end
      end
   end

   assign out_side = side_ff[N-1];
   assign out_q    = q_ff[N-1];

endmodule

// ===== rtl/quaternion_vector_rotate_core.sv =====
// Top level of the pipelined quaternion vector rotation core.
//
// Usage
//   Request beat (req_valid/req_ready): command plus quaternion (w,x,y,z) and
//   vector (x,y,z), all signed Q16.16. command 1 rotates by the inverse.
//   Response beat (rsp_valid/rsp_ready): rotated vector, saturated to 32 bits,
//   and status: ok, zero quaternion (vector forced to zero) or saturated.
// Throughput: one beat per cycle while not stalled; no dependence between beats.
// Pipeline: 76 register stages. The path is 6 front stages (abs, max,
//   leading one, block scale, square, sum), 32 square-root stages (one root
//   bit each), 1 + 31 divider stages (one quotient bit each), then sign,
//   qn*v products, round, t*conj(qn) products, round, and the clamp/output
//   register.
// Stall: the whole pipe advances together. When a response is held with
//   rsp_ready low, every stage holds and req_ready drops in the same cycle;
//   nothing is dropped or repeated, and bubbles travel as invalid stages.
// Reset (synchronous, active high) clears every stage valid bit; no result
//   is presented until a new request has gone through the pipe.
module quaternion_vector_rotate_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic signed [31:0] req_quat_w,
   input  logic signed [31:0] req_quat_x,
   input  logic signed [31:0] req_quat_y,
   input  logic signed [31:0] req_quat_z,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_rot_x,
   output logic signed [31:0] rsp_rot_y,
   output logic signed [31:0] rsp_rot_z,
   output logic [1:0]         rsp_status
);

   localparam int DW   = qvr_pkg::DATA_W;
   localparam int MW   = qvr_pkg::MAG_W;
   localparam int QF   = qvr_pkg::QN_FRAC;
   localparam int QW   = qvr_pkg::Q_W;
   localparam int TW   = qvr_pkg::T_W;
   localparam int P1W  = qvr_pkg::P1_W;
   localparam int S1W  = qvr_pkg::S1_W;
   localparam int P2W  = qvr_pkg::P2_W;
   localparam int S2W  = qvr_pkg::S2_W;
   localparam int RRW  = qvr_pkg::R_W;

   localparam logic [DW-1:0]         BIG_LIM = DW'(1) << QF;       // scale down above
   localparam logic signed [S1W-1:0] HALF1   = S1W'(1) <<< (QF - 1);
   localparam logic signed [S2W-1:0] HALF2   = S2W'(1) <<< (QF - 1);
   localparam logic signed [RRW-1:0] R_MAX   = RRW'(2147483647);
   localparam logic signed [RRW-1:0] R_MIN   = -R_MAX - RRW'(1);

   logic en;
   logic out_valid_ff;

   // whole pipe moves unless a finished beat is waiting
   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---------------- A: sign and magnitude
   qvr_pkg::dv_side_type   a_side_ff;
   logic [3:0][DW-1:0]     a_mag_ff;
   logic signed [DW-1:0]   q_in [4];

   assign q_in[0] = req_quat_w;
   assign q_in[1] = req_quat_x;
   assign q_in[2] = req_quat_y;
   assign q_in[3] = req_quat_z;

   always_ff @(posedge clock) begin
      if (en && !reset) begin
         a_side_ff.valid  <= req_valid;
         a_side_ff.cmd    <= req_command;
         a_side_ff.zero   <= 1'b0;
         a_side_ff.vec[0] <= req_vec_x;
         a_side_ff.vec[1] <= req_vec_y;
         a_side_ff.vec[2] <= req_vec_z;
         for (int i = 0; i < 4; i++) begin
            a_side_ff.neg[i] <= q_in[i][DW-1];
            a_mag_ff[i]      <= q_in[i][DW-1] ? DW'(-q_in[i]) : DW'(q_in[i]);
         end
      end
      if (reset) begin
         a_side_ff.valid <= 1'b0;
      end
   end

   // ---------------- B: largest magnitude
   qvr_pkg::dv_side_type b_side_ff;
   logic [3:0][DW-1:0]   b_mag_ff;
   logic [DW-1:0]        b_mx_ff, mx_01, mx_23, mx_in;

   always_comb begin
      mx_01 = (a_mag_ff[0] > a_mag_ff[1]) ? a_mag_ff[0] : a_mag_ff[1];
      mx_23 = (a_mag_ff[2] > a_mag_ff[3]) ? a_mag_ff[2] : a_mag_ff[3];
      mx_in = (mx_01 > mx_23) ? mx_01 : mx_23;
   end

   always_ff @(posedge clock) begin
      if (en && !reset) begin
         b_side_ff <= a_side_ff;
         b_mag_ff  <= a_mag_ff;
         b_mx_ff   <= mx_in;
      end
      if (reset) begin
         b_side_ff.valid <= 1'b0;
      end
   end

   // ---------------- C: leading one, scale decision
   qvr_pkg::dv_side_type c_side_ff, c_side_in;
   logic [3:0][DW-1:0]   c_mag_ff;
   logic [4:0]           c_sh_ff, msb, sh_in;
   logic                 c_big_ff;

   always_comb begin
      msb = '0;
      for (int i = 0; i < DW; i++) begin
         if (b_mx_ff[i]) begin
            msb = 5'(i);
         end
      end
      sh_in = (msb < 5'(QF - 1)) ? (5'(QF - 1) - msb) : '0;
      c_side_in      = b_side_ff;
      c_side_in.zero = (b_mx_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en && !reset) begin
         c_side_ff      <= c_side_in;
         c_mag_ff       <= b_mag_ff;
         c_sh_ff        <= sh_in;
         c_big_ff       <= (b_mx_ff > BIG_LIM);
      end
      if (reset) begin
         c_side_ff.valid <= 1'b0;
      end
   end

   // ---------------- D: block scaling
   qvr_pkg::dv_side_type d_side_ff;
   logic [3:0][MW-1:0]   d_mag_ff;

   always_ff @(posedge clock) begin
      if (en && !reset) begin
         d_side_ff <= c_side_ff;
         for (int i = 0; i < 4; i++) begin
            d_mag_ff[i] <= c_big_ff ? MW'(c_mag_ff[i] >> 1) : MW'(c_mag_ff[i] << c_sh_ff);
         end
      end
      if (reset) begin
         d_side_ff.valid <= 1'b0;
      end
   end

   // ---------------- E: squares
   qvr_pkg::dv_side_type           e_side_ff;
   logic [3:0][MW-1:0]             e_mag_ff;
   logic [3:0][qvr_pkg::SQ_W-1:0]  e_sq_ff;

   always_ff @(posedge clock) begin
      if (en && !reset) begin
         e_side_ff <= d_side_ff;
         e_mag_ff  <= d_mag_ff;
         for (int i = 0; i < 4; i++) begin
            e_sq_ff[i] <= qvr_pkg::SQ_W'(d_mag_ff[i]) * qvr_pkg::SQ_W'(d_mag_ff[i]);
         end
      end
      if (reset) begin
         e_side_ff.valid <= 1'b0;
      end
   end

   // ---------------- F: norm squared
   qvr_pkg::sq_side_type          f_side_ff;
   logic [qvr_pkg::SUM_W-1:0]     f_sum_ff;

   always_ff @(posedge clock) begin
      if (en && !reset) begin
         f_side_ff.base <= e_side_ff;
         f_side_ff.mag  <= e_mag_ff;
         f_sum_ff       <= qvr_pkg::SUM_W'(e_sq_ff[0]) + qvr_pkg::SUM_W'(e_sq_ff[1])
                         + qvr_pkg::SUM_W'(e_sq_ff[2]) + qvr_pkg::SUM_W'(e_sq_ff[3]);
      end
      if (reset) begin
         f_side_ff.base.valid <= 1'b0;
      end
   end

   // ---------------- norm and unit quaternion
   qvr_pkg::sq_side_type          sq_side;
   logic [qvr_pkg::ROOT_W-1:0]    sq_root;
   qvr_pkg::dv_side_type          dv_side;
   logic [3:0][QW-1:0]            dv_q;

   qvr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_side  (f_side_ff),
      .in_sum   (f_sum_ff),
      .out_side (sq_side),
      .out_root (sq_root)
   );

   qvr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_side  (sq_side.base),
      .in_mag   (sq_side.mag),
      .in_m     (sq_root),
      .out_side (dv_side),
      .out_q    (dv_q)
   );

   // ---------------- G: signs back, inverse conjugates the vector part
   logic                 g_valid_ff, g_zero_ff;
   logic signed [DW-1:0] g_qn_ff  [4];
   logic signed [DW-1:0] g_vec_ff [3];
   logic                 flip [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         flip[i] = dv_side.neg[i] ^ ((i != 0) && (dv_side.cmd == qvr_pkg::CMD_INVERSE));
      end
   end

   always_ff @(posedge clock) begin
      if (en && !reset) begin
         g_valid_ff <= dv_side.valid;
         g_zero_ff  <= dv_side.zero;
         for (int i = 0; i < 4; i++) begin
            g_qn_ff[i] <= flip[i] ? -$signed(DW'(dv_q[i])) : $signed(DW'(dv_q[i]));
         end
         for (int i = 0; i < 3; i++) begin
            g_vec_ff[i] <= $signed(dv_side.vec[i]);
         end
      end
      if (reset) begin
         g_valid_ff <= 1'b0;
      end
   end

   // ---------------- H: qn * (0, v) partial products
   logic                  h_valid_ff, h_zero_ff;
   logic signed [DW-1:0]  h_qn_ff [4];
   logic signed [P1W-1:0] h_p_ff  [12];

   always_ff @(posedge clock) begin
      if (en && !reset) begin
         h_valid_ff <= g_valid_ff;
         h_zero_ff  <= g_zero_ff;
         h_qn_ff    <= g_qn_ff;
         // t0 terms: x vx, y vy, z vz
         h_p_ff[0]  <= g_qn_ff[1] * g_vec_ff[0];
         h_p_ff[1]  <= g_qn_ff[2] * g_vec_ff[1];
         h_p_ff[2]  <= g_qn_ff[3] * g_vec_ff[2];
         // t1 terms: w vx, y vz, z vy
         h_p_ff[3]  <= g_qn_ff[0] * g_vec_ff[0];
         h_p_ff[4]  <= g_qn_ff[2] * g_vec_ff[2];
         h_p_ff[5]  <= g_qn_ff[3] * g_vec_ff[1];
         // t2 terms: w vy, x vz, z vx
         h_p_ff[6]  <= g_qn_ff[0] * g_vec_ff[1];
         h_p_ff[7]  <= g_qn_ff[1] * g_vec_ff[2];
         h_p_ff[8]  <= g_qn_ff[3] * g_vec_ff[0];
         // t3 terms: w vz, x vy, y vx
         h_p_ff[9]  <= g_qn_ff[0] * g_vec_ff[2];
         h_p_ff[10] <= g_qn_ff[1] * g_vec_ff[1];
         h_p_ff[11] <= g_qn_ff[2] * g_vec_ff[0];
      end
      if (reset) begin
         h_valid_ff <= 1'b0;
      end
   end

   // ---------------- I: sums, round half up by 2^30
   logic                  i_valid_ff, i_zero_ff;
   logic signed [DW-1:0]  i_qn_ff [4];
   logic signed [TW-1:0]  i_t_ff  [4];
   logic signed [S1W-1:0] s1 [4];
   logic signed [S1W-1:0] hp [12];

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         hp[i] = S1W'(h_p_ff[i]);
      end
      s1[0] = -hp[0] - hp[1] - hp[2];
      s1[1] =  hp[3] + hp[4] - hp[5];
      s1[2] =  hp[6] - hp[7] + hp[8];
      s1[3] =  hp[9] + hp[10] - hp[11];
   end

   always_ff @(posedge clock) begin
      if (en && !reset) begin
         i_valid_ff <= h_valid_ff;
         i_zero_ff  <= h_zero_ff;
         i_qn_ff    <= h_qn_ff;
         for (int i = 0; i < 4; i++) begin
            i_t_ff[i] <= TW'((s1[i] + HALF1) >>> QF);
         end
      end
      if (reset) begin
         i_valid_ff <= 1'b0;
      end
   end

   // ---------------- J: t * conj(qn) partial products
   logic                  j_valid_ff, j_zero_ff;
   logic signed [P2W-1:0] j_p_ff [12];

   always_ff @(posedge clock) begin
      if (en && !reset) begin
         j_valid_ff <= i_valid_ff;
         j_zero_ff  <= i_zero_ff;
         // r0: t1 w, t0 x, t2 z, t3 y
         j_p_ff[0]  <= i_t_ff[1] * i_qn_ff[0];
         j_p_ff[1]  <= i_t_ff[0] * i_qn_ff[1];
         j_p_ff[2]  <= i_t_ff[2] * i_qn_ff[3];
         j_p_ff[3]  <= i_t_ff[3] * i_qn_ff[2];
         // r1: t2 w, t0 y, t1 z, t3 x
         j_p_ff[4]  <= i_t_ff[2] * i_qn_ff[0];
         j_p_ff[5]  <= i_t_ff[0] * i_qn_ff[2];
         j_p_ff[6]  <= i_t_ff[1] * i_qn_ff[3];
         j_p_ff[7]  <= i_t_ff[3] * i_qn_ff[1];
         // r2: t3 w, t0 z, t1 y, t2 x
         j_p_ff[8]  <= i_t_ff[3] * i_qn_ff[0];
         j_p_ff[9]  <= i_t_ff[0] * i_qn_ff[3];
         j_p_ff[10] <= i_t_ff[1] * i_qn_ff[2];
         j_p_ff[11] <= i_t_ff[2] * i_qn_ff[1];
      end
      if (reset) begin
         j_valid_ff <= 1'b0;
      end
   end

   // ---------------- K: sums and rounding
   logic                  k_valid_ff, k_zero_ff;
   logic signed [RRW-1:0] k_r_ff [3];
   logic signed [S2W-1:0] s2 [3];
   logic signed [S2W-1:0] jp [12];

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         jp[i] = S2W'(j_p_ff[i]);
      end
      s2[0] = jp[0] - jp[1]  - jp[2]  + jp[3];
      s2[1] = jp[4] - jp[5]  + jp[6]  - jp[7];
      s2[2] = jp[8] - jp[9]  - jp[10] + jp[11];
   end

   always_ff @(posedge clock) begin
      if (en && !reset) begin
         k_valid_ff <= j_valid_ff;
         k_zero_ff  <= j_zero_ff;
         for (int i = 0; i < 3; i++) begin
            k_r_ff[i] <= RRW'((s2[i] + HALF2) >>> QF);
         end
      end
      if (reset) begin
         k_valid_ff <= 1'b0;
      end
   end

   // ---------------- L: clamp, status, output register
   logic signed [DW-1:0] rot_in [3];
   logic [2:0]           sat_in;
   logic [1:0]           status_in;
   logic signed [DW-1:0] rot_ff [3];
   logic [1:0]           status_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sat_in[i] = 1'b1;
         if (k_r_ff[i] > R_MAX) begin
            rot_in[i] = DW'(R_MAX);
         end else if (k_r_ff[i] < R_MIN) begin
            rot_in[i] = DW'(R_MIN);
         end else begin
            rot_in[i] = DW'(k_r_ff[i]);
            sat_in[i] = 1'b0;
         end
         if (k_zero_ff) begin
            rot_in[i] = '0;
         end
      end
      if (k_zero_ff) begin
         status_in = qvr_pkg::ST_ZERO;
      end else if (sat_in != '0) begin
         status_in = qvr_pkg::ST_SAT;
      end else begin
         status_in = qvr_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en && !reset) begin
         out_valid_ff <= k_valid_ff;
         rot_ff       <= rot_in;
         status_ff    <= status_in;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_rot_x  = rot_ff[0];
   assign rsp_rot_y  = rot_ff[1];
   assign rsp_rot_z  = rot_ff[2];
   assign rsp_status = status_ff;

   // ---------------- checks
   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == qvr_pkg::ST_ZERO |->
         rsp_rot_x == 0 && rsp_rot_y == 0 && rsp_rot_z == 0)
      else $error("zero quaternion with nonzero vector");

   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == qvr_pkg::ST_SAT |->
         rsp_rot_x == 32'sh7fffffff || rsp_rot_x == 32'sh80000000 ||
         rsp_rot_y == 32'sh7fffffff || rsp_rot_y == 32'sh80000000 ||
         rsp_rot_z == 32'sh7fffffff || rsp_rot_z == 32'sh80000000)
      else $error("saturation flagged with no clamped component");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(k_valid_ff) && $stable(dv_side.valid))
      else $error("pipe moved during stall");

endmodule

// ===== bench/quaternion_vector_rotate_core_tb.sv =====
// Self-checking bench for the quaternion vector rotation core.
`timescale 1ns / 100ps

module quaternion_vector_rotate_core_tb;

   localparam int MAX_CYCLES  = 300000;   // far above the slowest legal run
   localparam int IDLE_PCT    = 34;
   localparam int RAND_BEATS  = 1100;

   typedef struct {
      logic [31:0] x, y, z;
      logic [1:0]  status;
   } rot_result_type;

   // Predicts the rotated vector for each request beat and checks response
   // beats in order against it.
   class rotation_scoreboard;
      rot_result_type pending[$];
      int          errors;
      int          checked;
      int          zero_seen;
      int          sat_seen;

      function logic [63:0] isqrt(logic [63:0] x);
         logic [63:0] root;
         logic [63:0] b;
         root = 0;
         b    = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= root + b) begin
               x    = x - (root + b);
               root = (root >> 1) + b;
            end else begin
               root = root >> 1;
            end
            b = b >> 2;
         end
         return root;
      endfunction

      // round to nearest, halves up, then drop the Q2.30 fraction
      function logic [63:0] round30(logic [63:0] u);
         logic [63:0] t;
         t = u + (64'd1 << (qvr_pkg::QN_FRAC - 1));
         return 64'($signed(t) >>> qvr_pkg::QN_FRAC);
      endfunction

      function logic [31:0] clamp32(logic [63:0] u, inout bit hit);
         longint v;
         v = $signed(u);
         if (v > 64'sd2147483647) begin
            hit = 1;
            return 32'h7fff_ffff;
         end
         if (v < -64'sd2147483648) begin
            hit = 1;
            return 32'h8000_0000;
         end
         return u[31:0];
      endfunction

      function void note_request(logic cmd, logic [3:0][31:0] q, logic [2:0][31:0] vin);
         logic [63:0] mag[4];
         logic [63:0] qn[4];
         logic [63:0] v[3];
         logic [63:0] t[4];
         logic [63:0] r[3];
         logic [63:0] mx, s, m, a;
         logic [63:0] w, x, y, z;
         bit          neg[4];
         bit          hit;
         longint      c;
         rot_result_type e;
         mx  = 0;
         hit = 0;
         for (int i = 0; i < 4; i++) begin
            c      = $signed(q[i]);
            neg[i] = c < 0;
            mag[i] = neg[i] ? 64'(-c) : 64'(c);
            if (mag[i] > mx) mx = mag[i];
         end
         for (int i = 0; i < 3; i++) v[i] = 64'($signed(vin[i]));
         if (mx == 0) begin
            e = '{0, 0, 0, qvr_pkg::ST_ZERO};
            pending.push_back(e);
            return;
         end
         // block scaling into [2^29, 2^30]
         if (mx > (64'd1 << 30)) begin
            for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
         end else begin
            while (mx < (64'd1 << 29)) begin
               mx = mx << 1;
               for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
            end
         end
         s = 0;
         for (int i = 0; i < 4; i++) s = s + mag[i] * mag[i];
         m = isqrt(s);
         for (int i = 0; i < 4; i++) begin
            a     = ((mag[i] << qvr_pkg::QN_FRAC) + (m >> 1)) / m;
            qn[i] = neg[i] ? 64'd0 - a : a;
         end
         if (cmd == qvr_pkg::CMD_INVERSE)
            for (int i = 1; i < 4; i++) qn[i] = 64'd0 - qn[i];
         w = qn[0]; x = qn[1]; y = qn[2]; z = qn[3];
         t[0] = round30(64'd0 - x * v[0] - y * v[1] - z * v[2]);
         t[1] = round30(w * v[0] + y * v[2] - z * v[1]);
         t[2] = round30(w * v[1] - x * v[2] + z * v[0]);
         t[3] = round30(w * v[2] + x * v[1] - y * v[0]);
         r[0] = round30(t[1] * w - t[0] * x - t[2] * z + t[3] * y);
         r[1] = round30(t[2] * w - t[0] * y + t[1] * z - t[3] * x);
         r[2] = round30(t[3] * w - t[0] * z - t[1] * y + t[2] * x);
         e.x = clamp32(r[0], hit);
         e.y = clamp32(r[1], hit);
         e.z = clamp32(r[2], hit);
         e.status = hit ? qvr_pkg::ST_SAT : qvr_pkg::ST_OK;
         pending.push_back(e);
      endfunction

      function void check_response(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   logic [1:0] st);
         rot_result_type e;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: response beat with nothing outstanding");
            return;
         end
         e = pending.pop_front();
         if (st == qvr_pkg::ST_ZERO) zero_seen++;
         if (st == qvr_pkg::ST_SAT) sat_seen++;
         if (e.x !== x || e.y !== y || e.z !== z || e.status !== st) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: beat %0d exp %h %h %h st%0d got %h %h %h st%0d",
                        checked, e.x, e.y, e.z, e.status, x, y, z, st);
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic               req_command = 0;
   logic signed [31:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic signed [31:0] req_vec_x = 0, req_vec_y = 0, req_vec_z = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [31:0] rsp_rot_x, rsp_rot_y, rsp_rot_z;
   logic [1:0]         rsp_status;

   rotation_scoreboard board = new();
   bit steady = 0;         // no idling on either side while set
   int cycles = 0;

   always #2 clock = ~clock;

   quaternion_vector_rotate_core dut (.*);

   // Note accepted request beats; values sampled here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_request(req_command, {req_quat_z, req_quat_y, req_quat_x, req_quat_w},
                            {req_vec_z, req_vec_y, req_vec_x});
   end

   // Response side: check accepted beats, stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_status);
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Drive one request beat. An optional random gap lowers valid first; each
   // gap cycle is drawn on its own so about a third of the cycles idle.
   task automatic send_beat(logic cmd, logic [31:0] qw, logic [31:0] qx, logic [31:0] qy,
                            logic [31:0] qz, logic [31:0] vx, logic [31:0] vy,
                            logic [31:0] vz);
      int gap;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) gap++;
      end
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1;
      req_command <= cmd;
      req_quat_w  <= qw; req_quat_x <= qx; req_quat_y <= qy; req_quat_z <= qz;
      req_vec_x   <= vx; req_vec_y  <= vy; req_vec_z  <= vz;
      do @(posedge clock); while (!req_ready);
   endtask

   // Quaternion component with a random magnitude class so that block
   // scaling shifts both ways and by varied amounts.
   function automatic logic [31:0] rand_comp();
      logic [31:0] r;
      int          k;
      r = $urandom();
      k = $urandom_range(0, 9);
      case (k)
         0:       return 0;
         1:       return 32'h8000_0000;
         2, 3:    return 32'($signed(r) >>> $urandom_range(1, 31));
         default: return r;
      endcase
   endfunction

   function automatic logic [31:0] rand_vec();
      logic [31:0] r;
      r = $urandom();
      if ($urandom_range(0, 3) == 0) return r;            // full range, may saturate
      return 32'($signed(r) >>> $urandom_range(2, 20));   // mostly in range
   endfunction

   localparam logic [31:0] ONE  = 32'h0001_0000;
   localparam logic [31:0] MAXV = 32'h7fff_ffff;
   localparam logic [31:0] MINV = 32'h8000_0000;
   localparam logic [31:0] HALF = 32'h0000_b505;  // ~cos(45 deg) in Q16.16

   initial begin
      logic [31:0] q0, q1, q2, q3;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero quaternion, identity, quarter turns, scaling edges
      send_beat(0, 0, 0, 0, 0, ONE, ONE, ONE);
      send_beat(1, 0, 0, 0, 0, MAXV, MINV, MAXV);
      send_beat(0, ONE, 0, 0, 0, ONE, 32'hffff_0000, 32'h0003_8000);
      send_beat(0, HALF, 0, 0, HALF, ONE, 0, 0);
      send_beat(1, HALF, 0, 0, HALF, ONE, 0, 0);
      send_beat(0, HALF, HALF, 0, 0, 0, ONE, 0);
      send_beat(1, 0, 0, HALF, 0, 0, 0, ONE);
      send_beat(0, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV);
      send_beat(1, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV);
      send_beat(0, 32'h4000_0000, 0, 0, 0, MAXV, MINV, 0);
      send_beat(0, 32'h4000_0001, 1, 0, 0, MINV, MAXV, MAXV);
      send_beat(1, 32'h1fff_ffff, 0, 1, 0, MAXV, 0, MINV);
      send_beat(0, 1, 0, 0, 0, 5, 32'hffff_fffb, 7);
      send_beat(1, 0, 0, 0, 32'hffff_ffff, MAXV, MAXV, 0);
      send_beat(0, 0, MINV, 0, 0, 0, MAXV, MAXV);        // half turn
      send_beat(0, 0, MAXV, MAXV, 0, MAXV, MINV, MAXV);
      send_beat(1, 32'hc000_0000, 32'h4000_0000, 32'hc000_0000, 32'h4000_0000,
                32'hffff_ffff, 1, MINV);
      send_beat(0, 3, 32'hffff_fffd, 3, 32'hffff_fffd, 32'h5555_5555, 32'haaaa_aaaa, 0);

      // random beats; a stretch in the middle runs with no idling
      for (int i = 0; i < RAND_BEATS; i++) begin
         steady = (i >= 400 && i < 600);
         if ($urandom_range(0, 24) == 0) begin
            q0 = 0; q1 = 0; q2 = 0; q3 = 0;
         end else begin
            q0 = rand_comp(); q1 = rand_comp(); q2 = rand_comp(); q3 = rand_comp();
         end
         send_beat($urandom_range(0, 1), q0, q1, q2, q3, rand_vec(), rand_vec(), rand_vec());
      end
      steady = 0;
      req_valid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);

      $display("Checked %0d rotations in both directions: %0d zero-quaternion, %0d saturated.",
               board.checked, board.zero_seen, board.sat_seen);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
